[hdl/grt_pkg.sv]
// Shared types, constants and helpers for the grid raster tessellator.
package grt_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int VERTEX_BITS = 20;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int WID_BITS = COL_BITS + 1;
  localparam int CFG_BITS = 11;
  localparam int VIDX_BITS = 20;
  localparam int CNT_BITS = 22;
  localparam int DIR_BITS = 3;
  localparam int GRID_WIDTH_RESET = 1024;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_BITS = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_BITS = JOBQ_PTR_BITS + 1;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TRI = 1'b1;

  // Neighbor directions, clockwise from east.
  typedef enum logic [DIR_BITS-1:0] {
    DIR_E, DIR_SE, DIR_S, DIR_SW, DIR_W, DIR_NW, DIR_N, DIR_NE
  } dir_t;

  typedef struct packed {
    logic                 present;
    logic [VIDX_BITS-1:0] vertex_index;
    logic                 frame_start;
  } in_item_t;

  typedef struct packed {
    logic                 kind;
    logic [CNT_BITS-1:0]  element_index;
    logic [VIDX_BITS-1:0] vertex_a;
    logic [VIDX_BITS-1:0] vertex_b;
    logic [VIDX_BITS-1:0] vertex_c;
    logic [DIR_BITS-1:0]  dir_a;
    logic [DIR_BITS-1:0]  dir_b;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic                   present;
    logic [VERTEX_BITS-1:0] vtx;
  } cell_t;

  // One work entry: the 3x3 neighborhood needed to finish up to two cells.
  // The first job is centered on c; the second (row end) is centered on e.
  typedef struct packed {
    logic  clr;
    logic  do1;
    logic  do2;
    cell_t w;
    cell_t c;
    cell_t e;
    cell_t se;
    cell_t s;
    cell_t sw;
  } job_t;

  function automatic logic [VERTEX_BITS-1:0] vtx_from_in(input logic [VIDX_BITS-1:0] v);
    logic [VERTEX_BITS+VIDX_BITS-1:0] ext;
    ext = {{VERTEX_BITS{1'b0}}, v};
    return ext[VERTEX_BITS-1:0];
  endfunction

  function automatic logic [VIDX_BITS-1:0] vtx_to_out(input logic [VERTEX_BITS-1:0] v);
    logic [VERTEX_BITS+VIDX_BITS-1:0] ext;
    ext = {{VIDX_BITS{1'b0}}, v};
    return ext[VIDX_BITS-1:0];
  endfunction

endpackage

[hdl/grt_front.sv]
// Front end: takes cells, keeps the line store and windows, builds work entries.
module grt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [grt_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  grt_pkg::in_item_t             in_item,
  output logic                          q_push,
  output grt_pkg::job_t                 q_data,
  input  logic                          q_full
);

  logic [grt_pkg::CFG_BITS-1:0] grid_width_r;
  logic [grt_pkg::WID_BITS-1:0] width_eff;
  logic [grt_pkg::COL_BITS-1:0] col_r;
  logic [grt_pkg::COL_BITS-1:0] col_use;
  logic [grt_pkg::WID_BITS-1:0] col_inc;
  logic                         pv_r;
  logic                         pv_use;
  logic                         row_end;
  logic                         acc;
  grt_pkg::cell_t               in_cell;

  grt_pkg::cell_t row_mem [grt_pkg::MAX_WIDTH];
  grt_pkg::cell_t rd_cell_r;

  logic           s1_valid_r;
  grt_pkg::cell_t s1_cell_r;
  logic           s1_fs_r;
  logic           s1_colnz_r;
  logic           s1_end_r;
  logic           s1_pv_r;
  logic           s1_adv;
  logic           need_push;

  // Windows: cw0 is W of the next centre, cw1 the next centre;
  // pw1 and pw2 become SW and S of the next centre.
  grt_pkg::cell_t cw0_r;
  grt_pkg::cell_t cw1_r;
  grt_pkg::cell_t pw1_r;
  grt_pkg::cell_t pw2_r;
  grt_pkg::cell_t base_w;
  grt_pkg::cell_t base_c;
  grt_pkg::cell_t base_p1;
  grt_pkg::cell_t base_p2;
  grt_pkg::cell_t above;
  grt_pkg::job_t  job;

  always_comb begin
    if (grid_width_r == '0) begin
      width_eff = grt_pkg::WID_BITS'(1);
    end else if (32'(grid_width_r) > 32'(grt_pkg::MAX_WIDTH)) begin
      width_eff = grt_pkg::WID_BITS'(grt_pkg::MAX_WIDTH);
    end else begin
      width_eff = grt_pkg::WID_BITS'(grid_width_r);
    end
  end

  assign acc      = in_push & ~in_full;
  assign in_cell  = '{present: in_item.present, vtx: grt_pkg::vtx_from_in(in_item.vertex_index)};
  assign col_use  = in_item.frame_start ? '0 : col_r;
  assign pv_use   = in_item.frame_start ? 1'b0 : pv_r;
  assign col_inc  = {1'b0, col_use} + grt_pkg::WID_BITS'(1);
  assign row_end  = (col_inc >= width_eff);

  // Line store: read of the old entry and write of the new cell at one address.
  always_ff @(posedge clk) begin
    if (acc) begin
      row_mem[col_use] <= in_cell;
      rd_cell_r        <= row_mem[col_use];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cell_r  <= in_cell;
      s1_fs_r    <= in_item.frame_start;
      s1_colnz_r <= (col_use != '0);
      s1_end_r   <= row_end;
      s1_pv_r    <= pv_use;
    end
  end

  always_comb begin
    base_w  = s1_fs_r ? '0 : cw0_r;
    base_c  = s1_fs_r ? '0 : cw1_r;
    base_p1 = s1_fs_r ? '0 : pw1_r;
    base_p2 = s1_fs_r ? '0 : pw2_r;
    above   = s1_pv_r ? rd_cell_r : '0;
    job.clr = s1_fs_r;
    job.w   = base_w;
    job.c   = base_c;
    job.e   = s1_cell_r;
    job.se  = above;
    job.s   = base_p2;
    job.sw  = base_p1;
    job.do1 = s1_colnz_r & base_c.present &
              (s1_cell_r.present | above.present | base_p2.present | base_p1.present);
    job.do2 = s1_end_r & s1_cell_r.present & (above.present | base_p2.present);
  end

  assign need_push = job.clr | job.do1 | job.do2;
  assign s1_adv    = ~need_push | ~q_full;
  assign q_push    = s1_valid_r & need_push & ~q_full;
  assign q_data    = job;
  assign in_full   = s1_valid_r & ~s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= grt_pkg::CFG_BITS'(grt_pkg::GRID_WIDTH_RESET);
      col_r        <= '0;
      pv_r         <= 1'b0;
      s1_valid_r   <= 1'b0;
      cw0_r        <= '0;
      cw1_r        <= '0;
      pw1_r        <= '0;
      pw2_r        <= '0;
    end else begin
      if (cfg_we) begin
        grid_width_r <= cfg_wdata;
      end
      if (acc) begin
        col_r <= row_end ? '0 : col_inc[grt_pkg::COL_BITS-1:0];
        pv_r  <= row_end | pv_use;
      end
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_valid_r && s1_adv) begin
        if (s1_end_r) begin
          cw0_r <= '0;
          cw1_r <= '0;
          pw1_r <= '0;
          pw2_r <= '0;
        end else begin
          cw0_r <= base_c;
          cw1_r <= s1_cell_r;
          pw1_r <= base_p2;
          pw2_r <= above;
        end
      end
    end
  end

endmodule

[hdl/grt_jobq.sv]
// Short work queue between the front end and the back end.
module grt_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  grt_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output grt_pkg::job_t head,
  output logic          empty
);

  grt_pkg::job_t                     q_mem [grt_pkg::JOBQ_DEPTH];
  logic [grt_pkg::JOBQ_PTR_BITS-1:0] wr_r;
  logic [grt_pkg::JOBQ_PTR_BITS-1:0] rd_r;
  logic [grt_pkg::JOBQ_CNT_BITS-1:0] cnt_r;
  logic                              do_push;
  logic                              do_pop;

  assign full    = (cnt_r == grt_pkg::JOBQ_CNT_BITS'(grt_pkg::JOBQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = q_mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + grt_pkg::JOBQ_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_r <= rd_r + grt_pkg::JOBQ_PTR_BITS'(1);
      end
      cnt_r <= cnt_r + grt_pkg::JOBQ_CNT_BITS'(do_push) - grt_pkg::JOBQ_CNT_BITS'(do_pop);
    end
  end

endmodule

[hdl/grt_back.sv]
// Back end: walks neighbor steps; one result per cycle if output has room.
module grt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  grt_pkg::job_t      q_head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output grt_pkg::out_item_t out_item
);

  // Result slots in emission order.
  localparam logic [2:0] SLOT_E_EDGE  = 3'd0;
  localparam logic [2:0] SLOT_E_TRI   = 3'd1;
  localparam logic [2:0] SLOT_ES_TRI  = 3'd2;
  localparam logic [2:0] SLOT_SE_EDGE = 3'd3;
  localparam logic [2:0] SLOT_SE_TRI  = 3'd4;
  localparam logic [2:0] SLOT_S_EDGE  = 3'd5;
  localparam logic [2:0] SLOT_S_TRI   = 3'd6;
  localparam logic [2:0] SLOT_SW_EDGE = 3'd7;

  localparam logic [grt_pkg::DIR_BITS-1:0] DIR_OPP = 3'd4;

  logic                         phase_r;
  logic [7:0]                   done_r;
  logic                         started_r;
  logic [grt_pkg::CNT_BITS-1:0] edge_r;
  logic [grt_pkg::CNT_BITS-1:0] tri_r;

  logic           j2;
  logic           job_on;
  logic           cp;
  grt_pkg::cell_t n_cen, n_e, n_se, n_s, n_sw, n_w;
  logic [7:0]     en;
  logic [7:0]     pend;
  logic [7:0]     onehot;
  logic [7:0]     rest;
  logic [2:0]     sel;
  logic           have;
  logic           space;
  logic           emit;
  logic           job_done;
  logic           entry_done;
  logic           clr_now;
  logic [grt_pkg::CNT_BITS-1:0] edge_base;
  logic [grt_pkg::CNT_BITS-1:0] tri_base;

  logic                         r_kind;
  grt_pkg::cell_t               r_b;
  grt_pkg::cell_t               r_c;
  logic [grt_pkg::DIR_BITS-1:0] r_dir;
  grt_pkg::out_item_t           res;

  grt_pkg::out_item_t ob_mem [2];
  logic               ob_wr_r;
  logic               ob_rd_r;
  logic [1:0]         ob_cnt_r;
  logic               ob_pop;

  // The second job is centered on the east cell, with S and SW shifted over.
  assign j2     = phase_r | ~q_head.do1;
  assign job_on = j2 ? q_head.do2 : q_head.do1;
  assign n_cen  = j2 ? q_head.e  : q_head.c;
  assign n_e    = j2 ? '0        : q_head.e;
  assign n_se   = j2 ? '0        : q_head.se;
  assign n_s    = j2 ? q_head.se : q_head.s;
  assign n_sw   = j2 ? q_head.s  : q_head.sw;
  assign n_w    = j2 ? q_head.c  : q_head.w;
  assign cp     = job_on & ~q_empty & n_cen.present;

  always_comb begin
    en[SLOT_E_EDGE]  = cp & n_e.present;
    en[SLOT_E_TRI]   = cp & n_e.present & n_se.present;
    en[SLOT_ES_TRI]  = cp & n_e.present & ~n_se.present & n_s.present;
    en[SLOT_SE_EDGE] = cp & n_se.present;
    en[SLOT_SE_TRI]  = cp & n_se.present & n_s.present;
    en[SLOT_S_EDGE]  = cp & n_s.present;
    en[SLOT_S_TRI]   = cp & n_s.present & ~n_w.present & n_sw.present;
    en[SLOT_SW_EDGE] = cp & n_sw.present;
  end

  assign pend = en & ~done_r;
  assign have = |pend;

  always_comb begin
    sel = '0;
    for (int i = 7; i >= 0; i--) begin
      if (pend[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign onehot     = 8'b1 << sel;
  assign rest       = pend & ~onehot;
  assign space      = (ob_cnt_r != 2'd2);
  assign emit       = have & space;
  assign job_done   = emit & (rest == '0);
  assign entry_done = (~q_empty & ~have) | (job_done & (j2 | ~q_head.do2));
  assign q_pop      = entry_done;

  assign clr_now   = q_head.clr & ~started_r;
  assign edge_base = clr_now ? '0 : edge_r;
  assign tri_base  = clr_now ? '0 : tri_r;

  always_comb begin
    r_kind = grt_pkg::KIND_EDGE;
    r_b    = n_e;
    r_c    = '0;
    r_dir  = grt_pkg::DIR_E;
    unique case (sel)
      SLOT_E_EDGE: begin
        r_kind = grt_pkg::KIND_EDGE;
        r_b    = n_e;
        r_dir  = grt_pkg::DIR_E;
      end
      SLOT_E_TRI: begin
        r_kind = grt_pkg::KIND_TRI;
        r_b    = n_e;
        r_c    = n_se;
      end
      SLOT_ES_TRI: begin
        r_kind = grt_pkg::KIND_TRI;
        r_b    = n_e;
        r_c    = n_s;
      end
      SLOT_SE_EDGE: begin
        r_kind = grt_pkg::KIND_EDGE;
        r_b    = n_se;
        r_dir  = grt_pkg::DIR_SE;
      end
      SLOT_SE_TRI: begin
        r_kind = grt_pkg::KIND_TRI;
        r_b    = n_se;
        r_c    = n_s;
      end
      SLOT_S_EDGE: begin
        r_kind = grt_pkg::KIND_EDGE;
        r_b    = n_s;
        r_dir  = grt_pkg::DIR_S;
      end
      SLOT_S_TRI: begin
        r_kind = grt_pkg::KIND_TRI;
        r_b    = n_s;
        r_c    = n_sw;
      end
      SLOT_SW_EDGE: begin
        r_kind = grt_pkg::KIND_EDGE;
        r_b    = n_sw;
        r_dir  = grt_pkg::DIR_SW;
      end
      default: begin
        r_kind = grt_pkg::KIND_EDGE;
      end
    endcase
  end

  always_comb begin
    res.kind          = r_kind;
    res.element_index = (r_kind == grt_pkg::KIND_EDGE) ? edge_base : tri_base;
    res.vertex_a      = grt_pkg::vtx_to_out(n_cen.vtx);
    res.vertex_b      = grt_pkg::vtx_to_out(r_b.vtx);
    res.vertex_c      = grt_pkg::vtx_to_out(r_c.vtx);
    res.dir_a         = (r_kind == grt_pkg::KIND_EDGE) ? r_dir : '0;
    res.dir_b         = (r_kind == grt_pkg::KIND_EDGE) ? (r_dir + DIR_OPP) : '0;
    res.last          = (rest == '0) & (j2 | ~q_head.do2);
  end

  assign ob_pop    = out_pop & ~out_empty;
  assign out_empty = (ob_cnt_r == 2'd0);
  assign out_item  = ob_mem[ob_rd_r];

  always_ff @(posedge clk) begin
    if (emit) begin
      ob_mem[ob_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      done_r    <= '0;
      started_r <= 1'b0;
      edge_r    <= '0;
      tri_r     <= '0;
      ob_wr_r   <= 1'b0;
      ob_rd_r   <= 1'b0;
      ob_cnt_r  <= 2'd0;
    end else begin
      if (entry_done) begin
        phase_r   <= 1'b0;
        done_r    <= '0;
        started_r <= 1'b0;
      end else if (job_done) begin
        phase_r   <= 1'b1;
        done_r    <= '0;
        started_r <= 1'b1;
      end else if (emit) begin
        done_r    <= done_r | onehot;
        started_r <= 1'b1;
      end
      if (emit || entry_done) begin
        edge_r <= edge_base + grt_pkg::CNT_BITS'(emit & (r_kind == grt_pkg::KIND_EDGE));
        tri_r  <= tri_base + grt_pkg::CNT_BITS'(emit & (r_kind == grt_pkg::KIND_TRI));
      end
      if (emit) begin
        ob_wr_r <= ~ob_wr_r;
      end
      if (ob_pop) begin
        ob_rd_r <= ~ob_rd_r;
      end
      ob_cnt_r <= ob_cnt_r + 2'(emit) - 2'(ob_pop);
    end
  end

endmodule

[hdl/grid_raster_tessellator_top.sv]
// Top level of the grid raster tessellator: front end, work queue, back end.
//
// Channel   Direction  Handshake          Payload
// in_       input      in_push / in_full  grt_pkg::in_item_t (present, vertex_index,
//                                         frame_start)
// out_      output     out_pop / out_empty grt_pkg::out_item_t (one edge or triangle)
// cfg_      input      cfg_we             cfg_wdata: grid_width
//
// A cell is taken in every cycle while the work queue has room. The front end
// reads the line store at the accepting edge and builds the work entry in the
// next cycle; the entry is written into the work queue when it has room, and
// the back end writes each result into the output buffer ahead of the ports.
// The back end emits one result per cycle while the output buffer has room; a
// cell gives zero to ten results (up to seven for the cell it finishes and up to
// three more at a row end); the single result write port into the two-entry
// output buffer sets the sustained rate.
// Reset is synchronous and clears all control state; the line store needs no
// clearing pass, since entries of the row before the first are masked as empty.
// A stall on the result side backs up through the output buffer and the work
// queue and then raises in_full; the front end keeps taking cells meanwhile.
module grid_raster_tessellator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  grt_pkg::in_item_t            in_item,
  output logic                         out_empty,
  input  logic                         out_pop,
  output grt_pkg::out_item_t           out_item,
  input  logic                         cfg_we,
  input  logic [grt_pkg::CFG_BITS-1:0] cfg_wdata
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  grt_pkg::job_t q_data;
  grt_pkg::job_t q_head;

  // The front end classifies each cell and builds the neighborhood entry.
  grt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  // The work queue lets the two halves stall independently.
  grt_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // The back end turns each entry into edges and triangles.
  grt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // The front end never pushes into a full work queue.
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("work queue written while full");

  // The input side only stalls because the work queue is full.
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_full)
    else $error("input stalled without a full work queue");

  // An edge carries one of the four forward directions and its opposite.
  a_edge_dirs: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == grt_pkg::KIND_EDGE) |->
      (out_item.dir_a[2] == 1'b0 && out_item.dir_b == {1'b1, out_item.dir_a[1:0]}))
    else $error("edge directions inconsistent");

  // A triangle carries no direction.
  a_tri_dirs: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == grt_pkg::KIND_TRI) |->
      (out_item.dir_a == '0 && out_item.dir_b == '0))
    else $error("triangle with direction fields set");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the grid raster tessellator: directed table, then random grids.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One row of the directed table. When typed is set, the result (if any) is
  // written in by hand and replaces what the predictor works out.
  typedef struct packed {
    logic                         set_cfg;
    logic [grt_pkg::CFG_BITS-1:0] cfg;
    grt_pkg::in_item_t            stim;
    logic                         typed;
    logic                         has_res;
    grt_pkg::out_item_t           res;
  } dir_row_t;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 32;
  localparam int RAND_CELLS    = 287;

  // Widths visited by the random part: the smallest, a few small ones, zero,
  // the largest and two values above it.
  localparam logic [12:0][grt_pkg::CFG_BITS-1:0] WIDTH_PLAN = {
    11'd2, 11'd1, 11'd5, 11'd0, 11'd3, 11'd16, 11'd2047,
    11'd4, 11'd1024, 11'd7, 11'd1025, 11'd2, 11'd6
  };

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_push;
  logic                         in_full;
  grt_pkg::in_item_t            in_item;
  logic                         out_empty;
  logic                         out_pop;
  grt_pkg::out_item_t           out_item;
  logic                         cfg_we;
  logic [grt_pkg::CFG_BITS-1:0] cfg_wdata;

  grid_raster_tessellator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tessellation predictor. It mirrors the block's architectural state: the
  // line store holding the row below, the sliding windows over the current
  // and the previous row, the column and the two running counters.
  // ---------------------------------------------------------------------------
  logic [grt_pkg::CFG_BITS-1:0] width_reg;
  grt_pkg::cell_t               line_mem [grt_pkg::MAX_WIDTH];
  logic                         row_below_valid;
  int unsigned                  col_pos;
  grt_pkg::cell_t [1:0]         cur_win;   // [0] is west, [1] is the waiting centre
  grt_pkg::cell_t [2:0]         below_win; // [0] is SW, [1] is S, [2] is SE
  logic [grt_pkg::CNT_BITS-1:0] edge_cnt;
  logic [grt_pkg::CNT_BITS-1:0] tri_cnt;

  // Results of the cell being predicted, before they join the expectation queue.
  grt_pkg::out_item_t [15:0] step_buf;
  int                        step_n;

  grt_pkg::out_item_t pending_q [$];
  dir_row_t           dir_tab [$];
  int unsigned        err_cnt;
  int unsigned        cells_sent;
  int unsigned        edges_seen;
  int unsigned        tris_seen;
  int unsigned        widths_used;
  int unsigned        cycle_cnt = 0;
  bit                 send_burst;
  bit                 pop_burst;

  function automatic int unsigned eff_width(input logic [grt_pkg::CFG_BITS-1:0] w);
    if (w == 0) return 1;
    if (w > grt_pkg::MAX_WIDTH) return grt_pkg::MAX_WIDTH;
    return 32'(w);
  endfunction

  function automatic void clear_frame();
    row_below_valid = 1'b0;
    col_pos = 0;
    cur_win = '0;
    below_win = '0;
    edge_cnt = '0;
    tri_cnt = '0;
  endfunction

  function automatic void exp_add(input grt_pkg::out_item_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void emit(input logic kind, input logic [grt_pkg::CNT_BITS-1:0] idx,
                               input grt_pkg::cell_t a, input grt_pkg::cell_t b,
                               input grt_pkg::cell_t c, input grt_pkg::dir_t d);
    grt_pkg::out_item_t r;
    r = '0;
    r.kind = kind;
    r.element_index = idx;
    r.vertex_a = a.vtx;
    r.vertex_b = b.vtx;
    r.vertex_c = c.vtx;
    if (kind == grt_pkg::KIND_EDGE) begin
      r.dir_a = d;
      r.dir_b = d + 3'd4;
    end
    if (step_n < 16) begin
      step_buf[step_n] = r;
      step_n++;
    end
  endfunction

  // Edges and triangles of one centre cell, given its E, SE, S, SW and W cells.
  function automatic void finish_cell(input grt_pkg::cell_t ctr,
                                      input grt_pkg::cell_t [4:0] nb);
    grt_pkg::cell_t blank;
    blank = '0;
    if (!ctr.present) return;
    for (int i = grt_pkg::DIR_E; i <= grt_pkg::DIR_SW; i++) begin
      if (!nb[i].present) continue;
      emit(grt_pkg::KIND_EDGE, edge_cnt, ctr, nb[i], blank, grt_pkg::dir_t'(i));
      edge_cnt++;
      // Triangle with the next neighbor clockwise; the S and SW steps only
      // close one when the west cell is empty.
      if ((!nb[grt_pkg::DIR_W].present || i <= grt_pkg::DIR_SE) && nb[i+1].present) begin
        emit(grt_pkg::KIND_TRI, tri_cnt, ctr, nb[i], nb[i+1], grt_pkg::DIR_E);
        tri_cnt++;
      end
      // The irregular E-S triangle bridges a missing SE cell.
      if (i == grt_pkg::DIR_E && !nb[grt_pkg::DIR_SE].present &&
          nb[grt_pkg::DIR_S].present) begin
        emit(grt_pkg::KIND_TRI, tri_cnt, ctr, nb[grt_pkg::DIR_E], nb[grt_pkg::DIR_S],
             grt_pkg::DIR_E);
        tri_cnt++;
      end
    end
  endfunction

  function automatic void predict(input grt_pkg::in_item_t it);
    int unsigned          w;
    int unsigned          col;
    grt_pkg::cell_t       cur;
    grt_pkg::cell_t       above;
    grt_pkg::cell_t [4:0] nb;
    w = eff_width(width_reg);
    step_n = 0;
    if (it.frame_start) clear_frame();
    cur.present = it.present;
    cur.vtx = it.vertex_index;
    col = col_pos;
    above = row_below_valid ? line_mem[col] : '0;
    below_win[0] = below_win[1];
    below_win[1] = below_win[2];
    below_win[2] = above;
    // The arriving cell is the east neighbor of the waiting centre.
    if (col > 0) begin
      nb[grt_pkg::DIR_E]  = cur;
      nb[grt_pkg::DIR_SE] = below_win[2];
      nb[grt_pkg::DIR_S]  = below_win[1];
      nb[grt_pkg::DIR_SW] = below_win[0];
      nb[grt_pkg::DIR_W]  = cur_win[0];
      finish_cell(cur_win[1], nb);
    end
    cur_win[0] = cur_win[1];
    cur_win[1] = cur;
    line_mem[col] = cur;
    // At the row end the new cell is finished at once, with nothing to the east.
    if (col + 1 >= w) begin
      nb[grt_pkg::DIR_E]  = '0;
      nb[grt_pkg::DIR_SE] = '0;
      nb[grt_pkg::DIR_S]  = below_win[2];
      nb[grt_pkg::DIR_SW] = below_win[1];
      nb[grt_pkg::DIR_W]  = cur_win[0];
      finish_cell(cur, nb);
      row_below_valid = 1'b1;
      col_pos = 0;
      cur_win = '0;
      below_win = '0;
    end else begin
      col_pos = col + 1;
    end
    if (step_n > 0) step_buf[step_n-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------
  function automatic void cmp(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic void check_result(input grt_pkg::out_item_t got);
    grt_pkg::out_item_t want;
    if (pending_q.size() == 0) begin
      $error("result transaction with nothing expected: %h", got);
      err_cnt++;
      return;
    end
    want = pending_q.pop_front();
    cmp("kind", 32'(want.kind), 32'(got.kind));
    cmp("element_index", 32'(want.element_index), 32'(got.element_index));
    cmp("vertex_a", 32'(want.vertex_a), 32'(got.vertex_a));
    cmp("vertex_b", 32'(want.vertex_b), 32'(got.vertex_b));
    cmp("vertex_c", 32'(want.vertex_c), 32'(got.vertex_c));
    cmp("dir_a", 32'(want.dir_a), 32'(got.dir_a));
    cmp("dir_b", 32'(want.dir_b), 32'(got.dir_b));
    cmp("last", 32'(want.last), 32'(got.last));
    if (got.kind == grt_pkg::KIND_EDGE) edges_seen++;
    else tris_seen++;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers.
  // ---------------------------------------------------------------------------
  function automatic grt_pkg::out_item_t typed_edge(
      input logic [grt_pkg::CNT_BITS-1:0] idx,
      input logic [grt_pkg::VIDX_BITS-1:0] a,
      input logic [grt_pkg::VIDX_BITS-1:0] b,
      input grt_pkg::dir_t d);
    grt_pkg::out_item_t r;
    r = '0;
    r.kind = grt_pkg::KIND_EDGE;
    r.element_index = idx;
    r.vertex_a = a;
    r.vertex_b = b;
    r.dir_a = d;
    r.dir_b = d + 3'd4;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input logic set_cfg,
                                  input logic [grt_pkg::CFG_BITS-1:0] cfg,
                                  input logic p, input logic [grt_pkg::VIDX_BITS-1:0] v,
                                  input logic fs, input logic typed,
                                  input logic has_res, input grt_pkg::out_item_t res);
    dir_row_t r;
    r.set_cfg = set_cfg;
    r.cfg = cfg;
    r.stim.present = p;
    r.stim.vertex_index = v;
    r.stim.frame_start = fs;
    r.typed = typed;
    r.has_res = has_res;
    r.res = res;
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Every task returns just after a rising edge; inputs change
  // only at falling edges, and push stays high between back-to-back cells.
  // ---------------------------------------------------------------------------
  task automatic push_cell(input grt_pkg::in_item_t it, input logic typed,
                           input logic has_res, input grt_pkg::out_item_t res);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full !== 1'b0);
    // The transaction is taken at this edge.
    predict(it);
    if (typed) begin
      if (has_res) exp_add(res);
    end else begin
      for (int k = 0; k < step_n; k++) exp_add(step_buf[k]);
    end
    cells_sent++;
  endtask

  // Stop sending and wait for every expected result, then give the back end
  // time to chew through queued cells that produce nothing.
  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The width register is only written with the block idle.
  task automatic set_width(input logic [grt_pkg::CFG_BITS-1:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    width_reg = v;
    widths_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop with random stalls, sometimes in stretches with none.
  // ---------------------------------------------------------------------------
  initial begin : pop_side
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = pop_burst ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 24) == 0) pop_burst = !pop_burst;
      repeat (gap) begin
        @(negedge clk);
        out_pop <= 1'b0;
        @(posedge clk);
      end
      @(negedge clk);
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
      check_result(out_item);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    grt_pkg::out_item_t none;
    grt_pkg::in_item_t  it;
    int unsigned        rand_cells;
    int unsigned        phase;
    int unsigned        w;
    int unsigned        n;

    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    err_cnt = 0;
    cells_sent = 0;
    edges_seen = 0;
    tris_seen = 0;
    widths_used = 0;
    send_burst = 1'b0;
    pop_burst = 1'b0;
    none = '0;

    width_reg = grt_pkg::CFG_BITS'(grt_pkg::GRID_WIDTH_RESET);
    clear_frame();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first rows run at the reset width and check the
    // results by hand: a lone cell gives nothing until its east neighbor
    // comes, and then one E edge between the two extreme vertex numbers.
    add_row(0, 0, 1, 20'hFFFFF, 1, 1, 0, none);
    add_row(0, 0, 1, 20'h00000, 0, 1, 1,
            typed_edge(0, 20'hFFFFF, 20'h00000, grt_pkg::DIR_E));
    // Width zero behaves as width one. The frame start drops the cell still
    // waiting for its east neighbor, then a one-column grid links each cell
    // only to the one below it.
    add_row(1, 0, 1, 20'd5, 1, 1, 0, none);
    add_row(0, 0, 1, 20'd6, 0, 1, 1, typed_edge(0, 20'd6, 20'd5, grt_pkg::DIR_S));
    add_row(0, 0, 0, 20'hFFFFF, 0, 1, 0, none);
    // A width above the maximum is clamped.
    add_row(1, 2047, 1, 20'd1, 1, 0, 0, none);
    add_row(0, 0, 1, 20'd2, 0, 0, 0, none);
    add_row(0, 0, 1, 20'd3, 0, 0, 0, none);
    // Width three: two full rows give E-SE and SE-S triangles, a third row
    // with a hole gives S-SW with the west cell empty, and a fourth row with
    // SE empty gives the irregular E-S triangle.
    add_row(1, 3, 1, 20'd10, 1, 0, 0, none);
    for (int k = 11; k <= 15; k++) add_row(0, 0, 1, 20'(k), 0, 0, 0, none);
    add_row(0, 0, 1, 20'd20, 0, 0, 0, none);
    add_row(0, 0, 0, 20'd21, 0, 0, 0, none);
    add_row(0, 0, 1, 20'd22, 0, 0, 0, none);
    add_row(0, 0, 1, 20'd30, 0, 0, 0, none);
    add_row(0, 0, 1, 20'd31, 0, 0, 0, none);
    add_row(0, 0, 0, 20'd32, 0, 0, 0, none);
    // Lowering the width in the middle of a row: the next column is past the
    // new last column and closes the row.
    add_row(0, 0, 1, 20'd40, 0, 0, 0, none);
    add_row(1, 1, 1, 20'd41, 0, 0, 0, none);
    add_row(0, 0, 1, 20'd42, 0, 0, 0, none);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_cfg) set_width(dir_tab[i].cfg);
      push_cell(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].has_res, dir_tab[i].res);
    end

    // Random part: whole grids of random occupancy at each width of the plan.
    // Wide grids only get a handful of cells, since a row there is long.
    rand_cells = 0;
    phase = 0;
    while (rand_cells < RAND_CELLS) begin
      set_width(WIDTH_PLAN[phase % 13]);
      w = eff_width(width_reg);
      if (w > 64) n = $urandom_range(3, 8);
      else n = w * $urandom_range(2, 6) + $urandom_range(0, w - 1);
      send_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n && rand_cells < RAND_CELLS; k++) begin
        it.present = ($urandom_range(0, 3) != 0);
        it.vertex_index = 20'($urandom_range(0, 20'hFFFFF));
        // A stray frame start now and then restarts the grid mid-row.
        it.frame_start = (k == 0) || ($urandom_range(0, 49) == 0);
        push_cell(it, 1'b0, 1'b0, none);
        rand_cells++;
        if ($urandom_range(0, 59) == 0) drain();
      end
      phase++;
    end

    drain();

    $display("summary: %0d cells over %0d width settings; %0d edges, %0d triangles checked",
             cells_sent, widths_used, edges_seen, tris_seen);
    if (err_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
